>>> hdl/rsrd_pkg.sv
`default_nettype none

package rsrd_pkg;

	// Tag decoding
	localparam logic [7:0] TAG_ZERO_MIN = 8'h80;  // first zero-run tag
	localparam logic [7:0] TAG_REP_MIN  = 8'ha0;  // first repeat tag
	localparam logic [7:0] RUN_MASK     = 8'h1f;  // run length minus one

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IDX_W  = 16;
	localparam int unsigned DONE_W = 17;

	// Configuration register indexes
	localparam logic CFG_REG_BASE   = 1'b0;
	localparam logic CFG_WORD_COUNT = 1'b1;

	// One decoded word on its way from issue to the output register
	typedef struct packed {
		logic [IDX_W-1:0]  reg_idx;
		logic [WORD_W-1:0] lit_value;
		logic              use_ram;
		logic              last;
		logic              done;
	} word_req_t;

endpackage

`default_nettype wire

>>> hdl/register_stream_rle_decoder_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  -------------------------------------------
// in        sink       in_valid / in_stall    data_byte, first
// out       source     out_valid / out_stall  reg_index, word_value, last_of_run,
//                                             stream_done
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Flow: a zero-run tag, or a repeat token once its reference byte is taken, holds the input
//   while its run is issued, one word per cycle while the issue stage can advance, paced by
//   the single read port of the history RAM.
// Reset: arst_n clears the control state and the per-entry valid flags of the history,
//   so unwritten entries read as zero; no clearing pass is needed.
// Stalls: out_stall holds the output register and, through it, the issue stage and the
//   input; a finished word waits in the output register while the next is issued.

module register_stream_rle_decoder_unit #(
	parameter int unsigned HISTORY_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// encoded byte stream
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first,
	// decoded register writes
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      reg_index,
	output logic [31:0]      word_value,
	output logic             last_of_run,
	output logic             stream_done,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,  // waiting for a first-flagged byte
		ST_TAG,   // next byte is a tag
		ST_BACK,  // next byte is a back-reference
		ST_LIT,   // collecting literal bytes
		ST_RUN    // issuing a zero or repeat run, input held
	} state_t;

	// decoder state
	state_t                         state_q, state_d;
	logic [7:0]                     left_q, left_d;      // words left in token
	logic [1:0]                     pos_q, pos_d;        // literal byte position
	logic [23:0]                    partial_q, partial_d;
	logic [rsrd_pkg::DONE_W-1:0]    wd_q, wd_d;          // words done in stream
	logic [rsrd_pkg::IDX_W-1:0]     next_reg_q, next_reg_d;
	logic [7:0]                     back_q, back_d;
	logic [rsrd_pkg::IDX_W-1:0]     reg_base_q;
	logic [rsrd_pkg::IDX_W-1:0]     word_count_q;

	// issue stage (RAM read in flight)
	logic                           s1_valid_q;
	rsrd_pkg::word_req_t            s1_req_q;
	logic [HIST_AW-1:0]             s1_addr_q;
	logic                           s1_fwd_q;
	logic                           s1_hit_q;

	// history bookkeeping
	logic [HISTORY_DEPTH-1:0]       hist_vld_q;
	logic [rsrd_pkg::WORD_W-1:0]    last_wdata_q;
	logic [rsrd_pkg::WORD_W-1:0]    rd_data;

	// output register
	logic                           out_valid_q;
	logic [rsrd_pkg::IDX_W-1:0]     reg_index_q;
	logic [rsrd_pkg::WORD_W-1:0]    word_value_q;
	logic                           last_q;
	logic                           done_q;

	// combinational control
	logic                           out_free;
	logic                           s1_adv;
	logic                           issue_ok;
	logic                           in_acc;
	logic                           issue;
	rsrd_pkg::word_req_t            req;
	logic [HIST_AW-1:0]             iss_raddr;
	logic [rsrd_pkg::WORD_W-1:0]    s1_word;
	logic [rsrd_pkg::DONE_W-1:0]    wd_inc;
	logic                           done_test;
	logic                           tok_end;
	state_t                         cur_state;

	// the output register frees when empty or when its word leaves this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_adv    = s1_valid_q && out_free;
	assign issue_ok  = !s1_valid_q || s1_adv;
	assign in_stall  = (state_q == ST_RUN) || !issue_ok;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign out_valid   = out_valid_q;
	assign reg_index   = reg_index_q;
	assign word_value  = word_value_q;
	assign last_of_run = last_q;
	assign stream_done = done_q;

	// the stream ends once the count is reached at the end of a token
	assign wd_inc    = wd_q + rsrd_pkg::DONE_W'(1);
	assign done_test = wd_inc >= {1'b0, word_count_q};

	// word leaving the issue stage: forward a same-cycle write, zero unwritten entries
	always_comb begin
		if (s1_req_q.use_ram) begin
			if (s1_fwd_q) begin
				s1_word = last_wdata_q;
			end else if (s1_hit_q) begin
				s1_word = rd_data;
			end else begin
				s1_word = '0;
			end
		end else begin
			s1_word = s1_req_q.lit_value;
		end
	end

	// decode and issue
	always_comb begin
		state_d    = state_q;
		left_d     = left_q;
		pos_d      = pos_q;
		partial_d  = partial_q;
		wd_d       = wd_q;
		next_reg_d = next_reg_q;
		back_d     = back_q;
		issue      = 1'b0;
		req        = '0;
		iss_raddr  = wd_q[HIST_AW-1:0];
		tok_end    = 1'b0;
		cur_state  = state_q;

		if (in_acc) begin
			// first-flagged byte: reload counters, drop any open token
			if (first) begin
				cur_state  = (word_count_q == '0) ? ST_IDLE : ST_TAG;
				state_d    = cur_state;
				wd_d       = '0;
				next_reg_d = reg_base_q;
				pos_d      = '0;
				partial_d  = '0;
				left_d     = '0;
			end
			unique case (cur_state)
				ST_TAG: begin
					if (data_byte < rsrd_pkg::TAG_ZERO_MIN) begin
						left_d    = data_byte + 8'd1;
						pos_d     = '0;
						partial_d = '0;
						state_d   = ST_LIT;
					end else begin
						left_d = (data_byte & rsrd_pkg::RUN_MASK) + 8'd1;
						back_d = '0;
						state_d = (data_byte >= rsrd_pkg::TAG_REP_MIN) ? ST_BACK : ST_RUN;
					end
				end
				ST_BACK: begin
					back_d  = data_byte;
					state_d = ST_RUN;
				end
				ST_LIT: begin
					if (pos_q != 2'd3) begin
						case (pos_q)
							2'd0:    partial_d[7:0]   = data_byte;
							2'd1:    partial_d[15:8]  = data_byte;
							default: partial_d[23:16] = data_byte;
						endcase
						pos_d = pos_q + 2'd1;
					end else begin
						// fourth byte completes the word
						tok_end       = (left_q <= 8'd1);
						issue         = 1'b1;
						req.reg_idx   = next_reg_q;
						req.lit_value = {data_byte, partial_q};
						req.use_ram   = 1'b0;
						req.last      = 1'b1;
						req.done      = tok_end && done_test;
						wd_d          = wd_inc;
						next_reg_d    = next_reg_q + rsrd_pkg::IDX_W'(1);
						pos_d         = '0;
						partial_d     = '0;
						left_d        = (left_q != '0) ? left_q - 8'd1 : left_q;
						if (tok_end) begin
							state_d = done_test ? ST_IDLE : ST_TAG;
						end
					end
				end
				ST_IDLE, ST_RUN: begin
					// drop the byte
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end else if (state_q == ST_RUN && issue_ok) begin
			// one word of a zero or repeat run per cycle while the issue stage can advance
			tok_end       = (left_q <= 8'd1);
			issue         = 1'b1;
			req.reg_idx   = next_reg_q;
			req.lit_value = '0;
			req.use_ram   = (back_q != '0);
			req.last      = tok_end;
			req.done      = tok_end && done_test;
			iss_raddr     = HIST_AW'(wd_q - rsrd_pkg::DONE_W'(back_q));
			wd_d          = wd_inc;
			next_reg_d    = next_reg_q + rsrd_pkg::IDX_W'(1);
			left_d        = left_q - 8'd1;
			if (tok_end) begin
				state_d = done_test ? ST_IDLE : ST_TAG;
			end
		end
	end

	rsrd_ram #(
		.WIDTH (rsrd_pkg::WORD_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (s1_addr_q),
		.wdata (s1_word),
		.re    (issue),
		.raddr (iss_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			left_q       <= '0;
			pos_q        <= '0;
			partial_q    <= '0;
			wd_q         <= '0;
			next_reg_q   <= '0;
			back_q       <= '0;
			reg_base_q   <= '0;
			word_count_q <= '0;
			s1_valid_q   <= 1'b0;
			s1_req_q     <= '0;
			s1_addr_q    <= '0;
			s1_fwd_q     <= 1'b0;
			s1_hit_q     <= 1'b0;
			hist_vld_q   <= '0;
			last_wdata_q <= '0;
			out_valid_q  <= 1'b0;
			reg_index_q  <= '0;
			word_value_q <= '0;
			last_q       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			left_q     <= left_d;
			pos_q      <= pos_d;
			partial_q  <= partial_d;
			wd_q       <= wd_d;
			next_reg_q <= next_reg_d;
			back_q     <= back_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rsrd_pkg::CFG_REG_BASE:   reg_base_q   <= cfg_data;
					rsrd_pkg::CFG_WORD_COUNT: word_count_q <= cfg_data;
					default:                  reg_base_q   <= reg_base_q;
				endcase
			end

			// issue stage: capture the request, the valid flag and the forward hit
			if (issue) begin
				s1_valid_q <= 1'b1;
				s1_req_q   <= req;
				s1_addr_q  <= wd_q[HIST_AW-1:0];
				s1_fwd_q   <= s1_adv && (s1_addr_q == iss_raddr);
				s1_hit_q   <= hist_vld_q[iss_raddr];
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end

			// record the word in the history as it enters the output register
			if (s1_adv) begin
				hist_vld_q[s1_addr_q] <= 1'b1;
				last_wdata_q          <= s1_word;
				out_valid_q           <= 1'b1;
				reg_index_q           <= s1_req_q.reg_idx;
				word_value_q          <= s1_word;
				last_q                <= s1_req_q.last;
				done_q                <= s1_req_q.done;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/rsrd_ram.sv
`default_nettype none

module rsrd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read at the address being written returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/rsrd_checker.sv
`default_nettype none

module rsrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] reg_index,
	input wire logic [31:0] word_value,
	input wire logic        last_of_run,
	input wire logic        stream_done
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reg_index) && $stable(word_value)
			&& $stable(last_of_run) && $stable(stream_done))
		else $error("stalled result changed");

	// the stream ends only on the closing word of a token
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_run)
		else $error("stream_done without last_of_run");

	// words of one run carry consecutive register indexes
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_run) ##1 out_valid
			|-> reg_index == 16'($past(reg_index) + 16'd1))
		else $error("register index did not advance within a run");

endmodule

bind register_stream_rle_decoder_unit rsrd_checker u_rsrd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.reg_index   (reg_index),
	.word_value  (word_value),
	.last_of_run (last_of_run),
	.stream_done (stream_done)
);

`default_nettype wire

>>> dv/rle_word_checker.sv
module rle_word_checker
	import rsrd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [15:0] reg_index,
	input  wire logic [31:0] word_value,
	input  wire logic        last_of_run,
	input  wire logic        stream_done,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               mismatches = 0,
	output int               words_pending = 0,
	output int               words_checked = 0
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {DEC_IDLE, DEC_TAG, DEC_BACK, DEC_LIT} dec_phase_t;

	typedef struct packed {
		logic [IDX_W-1:0]  reg_index;
		logic [WORD_W-1:0] word_value;
		logic              last_of_run;
		logic              stream_done;
	} decoded_word_t;

	logic [IDX_W-1:0]  base_reg;
	logic [15:0]       count_reg;
	logic [WORD_W-1:0] history [16];
	dec_phase_t        phase;
	logic [7:0]        words_left;
	logic [1:0]        lit_pos;
	logic [23:0]       lit_partial;
	logic [DONE_W-1:0] words_done;
	logic [IDX_W-1:0]  next_reg;
	decoded_word_t     expected_words [$];
	int                n_err;
	int                n_ok;

	// Queue one decoded word and record it in the history.
	task automatic record_word(input logic [WORD_W-1:0] v);
		decoded_word_t w;
		w.reg_index   = next_reg;
		w.word_value  = v;
		w.last_of_run = 1'b0;
		w.stream_done = 1'b0;
		expected_words.push_back(w);
		history[words_done[3:0]] = v;
		next_reg   = next_reg + 1'b1;
		words_done = words_done + 1'b1;
	endtask

	// Flag the newest word as the last one of its byte; close the token if asked.
	task automatic close_run(input logic ends_token);
		decoded_word_t w;
		w = expected_words.pop_back();
		w.last_of_run = 1'b1;
		if (ends_token) begin
			words_left = '0;
			if (words_done >= {1'b0, count_reg}) begin
				phase = DEC_IDLE;
				w.stream_done = 1'b1;
			end else begin
				phase = DEC_TAG;
			end
		end
		expected_words.push_back(w);
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic f);
		int unsigned       n;
		logic [3:0]        slot;
		logic [WORD_W-1:0] v;
		if (f) begin
			words_done  = '0;
			next_reg    = base_reg;
			lit_pos     = '0;
			lit_partial = '0;
			words_left  = '0;
			phase       = (count_reg == 0) ? DEC_IDLE : DEC_TAG;
		end
		case (phase)
			DEC_TAG: begin
				n = (b & RUN_MASK) + 1;
				if (b < TAG_ZERO_MIN) begin
					words_left  = b + 8'd1;
					lit_pos     = '0;
					lit_partial = '0;
					phase       = DEC_LIT;
				end else if (b >= TAG_REP_MIN) begin
					words_left = 8'(n);
					phase      = DEC_BACK;
				end else begin
					repeat (n) record_word('0);
					close_run(1'b1);
				end
			end
			DEC_BACK: begin
				n = words_left;
				if (n == 0 || n > 32)
					n = 1;
				repeat (n) begin
					slot = words_done[3:0] - b[3:0];
					v = (b == 0) ? '0 : history[slot];
					record_word(v);
				end
				close_run(1'b1);
			end
			DEC_LIT: begin
				if (lit_pos < 3) begin
					lit_partial = lit_partial | (24'(b) << (8 * lit_pos));
					lit_pos     = lit_pos + 2'd1;
				end else begin
					record_word({b, lit_partial});
					lit_pos     = '0;
					lit_partial = '0;
					if (words_left > 0)
						words_left = words_left - 8'd1;
					close_run(words_left == 0);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_word_t w;
		if (!arst_n) begin
			base_reg    = '0;
			count_reg   = '0;
			phase       = DEC_IDLE;
			words_left  = '0;
			lit_pos     = '0;
			lit_partial = '0;
			words_done  = '0;
			next_reg    = '0;
			for (int i = 0; i < 16; i++)
				history[i] = '0;
			expected_words.delete();
			n_err = 0;
			n_ok  = 0;
			mismatches    <= 0;
			words_pending <= 0;
			words_checked <= 0;
		end else begin
			// compare before predicting so a stray word never matches a fresh request
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: reg_index %h word_value %h", reg_index, word_value);
					n_err++;
				end else begin
					w = expected_words.pop_front();
					n_ok++;
					if (reg_index !== w.reg_index) begin
						$error("reg_index: expected %h, actual %h", w.reg_index, reg_index);
						n_err++;
					end
					if (word_value !== w.word_value) begin
						$error("word_value: expected %h, actual %h", w.word_value, word_value);
						n_err++;
					end
					if (last_of_run !== w.last_of_run) begin
						$error("last_of_run: expected %b, actual %b", w.last_of_run, last_of_run);
						n_err++;
					end
					if (stream_done !== w.stream_done) begin
						$error("stream_done: expected %b, actual %b", w.stream_done, stream_done);
						n_err++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_REG_BASE)
					base_reg = cfg_data;
				else
					count_reg = cfg_data;
			end
			if (in_valid && !in_stall)
				decode_byte(data_byte, first);
			mismatches    <= n_err;
			words_pending <= expected_words.size();
			words_checked <= n_ok;
		end
	end

endmodule

>>> dv/register_stream_rle_decoder_unit_test.sv
module register_stream_rle_decoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rsrd_pkg::*;

	localparam int LONG_HOLD      = 300;   // receiver hold-off used to fill the block
	localparam int SETTLE         = 16;    // cycles allowed for words still in flight
	localparam int WATCHDOG_LIMIT = 4000;  // cycles without any accepted request
	localparam int RANDOM_BYTES   = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        first = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] reg_index;
	logic [31:0] word_value;
	logic        last_of_run;
	logic        stream_done;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_REG_BASE;
	logic [15:0] cfg_data = '0;

	int mismatches;
	int words_pending;
	int words_checked;

	// Pacing controls shared between the stimulus and the receiver.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_off_req = 1'b0;

	int bytes_sent = 0;
	int live_bytes = 0;    // decoded bytes of the random part, noise excluded
	int stream_words = 0;  // words the current stream has produced so far
	int streams_run = 0;
	int idle_cycles = 0;

	register_stream_rle_decoder_unit uut (.*);

	rle_word_checker word_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: end the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: stall in segments, one stall value per segment, so out_stall is
	// assigned at most once per edge. A hold-off request wins over everything else.
	initial begin
		int   len;
		logic hold;
		int   r;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold = 1'b1;
				len  = LONG_HOLD;
				hold_off_req = 1'b0;
			end else if (rx_steady) begin
				hold = 1'b0;
				len  = 1;
			end else begin
				r = $urandom_range(0, 19);
				if (r < 11) begin
					hold = 1'b0;
					len  = $urandom_range(1, 6);
				end else if (r < 18) begin
					hold = 1'b1;
					len  = $urandom_range(1, 3);
				end else begin
					hold = 1'b1;
					len  = $urandom_range(8, 40);
				end
			end
			out_stall <= hold;
			repeat (len) @(posedge clk);
		end
	end

	// Offer one byte after a random gap and hold it until the block takes it.
	// Valid stays high into the next request when no gap is drawn.
	task automatic send_byte(input logic [7:0] b, input logic f);
		int gap;
		int r;
		gap = 0;
		if (!tx_steady) begin
			r = $urandom_range(0, 19);
			if (r >= 18)
				gap = $urandom_range(8, 30);
			else if (r >= 12)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		first     <= f;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Pause the sender until every predicted word has left, then let stragglers settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both registers back to back; valid stays high between the two writes.
	task automatic set_config(input logic [15:0] base, input logic [15:0] count);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_REG_BASE;
		cfg_data  <= base;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_WORD_COUNT;
		cfg_data  <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_literal(input int n, input logic f);
		send_byte({1'b0, 7'(n - 1)}, f);
		repeat (4 * n) send_byte(8'($urandom), 1'b0);
		live_bytes   += 1 + 4 * n;
		stream_words += n;
	endtask

	task automatic send_zero_run(input int n, input logic f);
		send_byte({3'b100, 5'(n - 1)}, f);
		live_bytes   += 1;
		stream_words += n;
	endtask

	// Repeat tag with random upper bits (anything from the repeat range), then the back byte.
	task automatic send_repeat(input int n, input logic [7:0] back, input logic f);
		send_byte({1'b1, 2'($urandom_range(1, 3)), 5'(n - 1)}, f);
		send_byte(back, 1'b0);
		live_bytes   += 2;
		stream_words += n;
	endtask

	// Run length: mostly short, now and then up to the full 32.
	function automatic int pick_run();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
	endfunction

	// One random stream: fresh settings, well-formed tokens with random content,
	// now and then a token abandoned by a restart, and noise after the end.
	task automatic random_stream();
		logic [15:0] base;
		logic [15:0] count;
		logic [7:0]  back;
		logic        f;
		int          r;
		int          n;
		streams_run++;
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		r = $urandom_range(0, 7);
		if (r == 0)
			base = 16'h0000;
		else if (r == 1)
			base = 16'hFFFF;
		else if (r == 2)
			base = 16'($urandom_range(16'hFFE0, 16'hFFFF));
		else
			base = 16'($urandom);
		r = $urandom_range(0, 19);
		if (r == 0)
			count = 16'h0000;
		else if (r == 1)
			count = 16'hFFFF;
		else if (r < 5)
			count = 16'($urandom_range(40, 96));
		else
			count = 16'($urandom_range(1, 20));
		drain();
		set_config(base, count);
		stream_words = 0;
		f = 1'b1;
		if (count == 0) begin
			// zero word count: the flagged byte decodes nothing, the rest is ignored
			send_byte(8'($urandom), 1'b1);
			send_byte(8'($urandom), 1'b0);
			live_bytes += 1;
		end
		for (int t = 0; t < 10 && stream_words < count; t++) begin
			if ($urandom_range(0, 9) == 0) begin
				// broken token: leave it unfinished and restart the stream
				if ($urandom_range(0, 1) == 0) begin
					send_byte({1'b0, 7'($urandom)}, f);
					repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
				end else begin
					send_byte({1'b1, 2'($urandom_range(1, 3)), 5'($urandom)}, f);
				end
				live_bytes  += 1;
				stream_words = 0;
				f = 1'b1;
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
						send_literal(n, f);
					end
					1: send_zero_run(pick_run(), f);
					default: begin
						r = $urandom_range(0, 9);
						if (r == 0)
							back = 8'h00;
						else if (r == 1)
							back = 8'($urandom_range(16, 255));
						else
							back = 8'($urandom_range(1, 16));
						send_repeat(pick_run(), back, f);
					end
				endcase
				f = 1'b0;
			end
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- Directed part ---
		// Idle after reset: a byte without the start flag is dropped.
		send_byte(8'h00, 1'b0);

		// Zero word count: the flagged tag decodes nothing and the block stays idle.
		drain();
		set_config(16'hFFFE, 16'h0000);
		send_byte(8'h85, 1'b1);
		send_byte(8'h12, 1'b0);

		// Long stream near the index wrap: literal with extreme bytes, a full zero
		// run, a full repeat with back 255 (taken modulo 16), a repeat with back 0,
		// a repeat with back 16, then a 128-word literal abandoned by a restart,
		// whose stream then reads the stale history.
		drain();
		set_config(16'hFFFE, 16'hFFFF);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA2, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'hE3, 1'b1);
		send_byte(8'h03, 1'b0);

		// Stream end: the count is reached on the last word of a repeat token, later bytes drop.
		drain();
		set_config(16'hFFFF, 16'd3);
		send_byte(8'h81, 1'b1);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h55, 1'b0);

		// Count change mid-stream: lower the count between tokens; the base write
		// must not reload the index of the running stream.
		drain();
		set_config(16'h1234, 16'd4);
		send_byte(8'h80, 1'b1);
		drain();
		set_config(16'h4321, 16'd2);
		send_byte(8'h80, 1'b0);

		// --- Backpressure: hold the receiver while full zero runs keep coming ---
		drain();
		set_config(16'h0100, 16'd200);
		tx_steady    = 1'b1;
		hold_off_req = 1'b1;
		send_zero_run(32, 1'b1);
		repeat (4) send_zero_run(32, 1'b0);
		send_literal(2, 1'b0);
		tx_steady = 1'b0;

		// --- Random part ---
		live_bytes = 0;
		while (live_bytes < RANDOM_BYTES)
			random_stream();

		drain();
		$display("Run: %0d stream bytes over %0d random streams plus directed and backpressure phases,",
			bytes_sent, streams_run);
		$display("     %0d decoded words compared against the prediction.", words_checked);
		if (mismatches == 0 && words_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
